// ----- rtl/cfcp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfcp_pkg: shared types, constants and function of the framed command parser
// Holds the phase and status codes, the register indexes, the result record
// and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package cfcp_pkg;

    // Frame limits
    localparam int          MAX_PAYLOAD = 80;
    localparam logic [7:0]  LEN_MIN     = 8'd2;
    localparam logic [7:0]  LEN_MAX     = 8'(MAX_PAYLOAD + 2);
    // Body positions from two up to below this (four payload bytes) land in the word
    localparam logic [7:0]  WORD_END    = 8'd6;

    // CRC-16, polynomial 0x1021, MSB first
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    // Parser phases
    localparam logic [2:0]  PH_SYNC1    = 3'd0;
    localparam logic [2:0]  PH_SYNC2    = 3'd1;
    localparam logic [2:0]  PH_LENGTH   = 3'd2;
    localparam logic [2:0]  PH_BODY     = 3'd3;
    localparam logic [2:0]  PH_CRC_LO   = 3'd4;
    localparam logic [2:0]  PH_CRC_HI   = 3'd5;

    // Result status
    localparam logic [1:0]  ST_ACCEPTED     = 2'd0;
    localparam logic [1:0]  ST_BAD_PAYLOAD  = 2'd1;
    localparam logic [1:0]  ST_UNKNOWN_TYPE = 2'd2;

    // Decoded commands
    localparam logic [2:0]  CMD_SET_VOLTAGE = 3'd0;
    localparam logic [2:0]  CMD_SET_CURRENT = 3'd1;
    localparam logic [2:0]  CMD_SET_OUTPUT  = 3'd2;
    localparam logic [2:0]  CMD_PING        = 3'd3;
    localparam logic [2:0]  CMD_NONE        = 3'd4;

    // Configuration register indexes
    localparam logic [2:0]  REG_SYNC_FIRST       = 3'd0;
    localparam logic [2:0]  REG_SYNC_SECOND      = 3'd1;
    localparam logic [2:0]  REG_CODE_SET_VOLTAGE = 3'd2;
    localparam logic [2:0]  REG_CODE_SET_CURRENT = 3'd3;
    localparam logic [2:0]  REG_CODE_SET_OUTPUT  = 3'd4;
    localparam logic [2:0]  REG_CODE_PING        = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_SYNC_FIRST       = 8'hAA;
    localparam logic [7:0]  RST_SYNC_SECOND      = 8'h55;
    localparam logic [7:0]  RST_CODE_SET_VOLTAGE = 8'd1;
    localparam logic [7:0]  RST_CODE_SET_CURRENT = 8'd2;
    localparam logic [7:0]  RST_CODE_SET_OUTPUT  = 8'd3;
    localparam logic [7:0]  RST_CODE_PING        = 8'd4;

    // Payload lengths that each command needs
    localparam logic [7:0]  PLEN_TARGET = 8'd4;
    localparam logic [7:0]  PLEN_OUTPUT = 8'd1;
    localparam logic [7:0]  PLEN_PING   = 8'd0;

    typedef struct packed {
        logic [7:0] set_voltage;
        logic [7:0] set_current;
        logic [7:0] set_output;
        logic [7:0] ping;
    } cmd_codes_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  msg_type;
        logic [7:0]  sequence_res;
        logic [2:0]  command;
        logic [31:0] value;
    } result_t;

    // Advance the CRC by one byte, one shift per bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/crc16_framed_command_parser_core.sv -----
// ----------------------------------------------------------------------------
// crc16_framed_command_parser_core: sync / length / CRC-16 frame parser
// Hunts for two sync bytes, reads a length and body, checks a little-endian
// CRC-16 and delivers one decoded command per good frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; the CRC byte update
//   and the parse step both finish in the cycle the byte is taken.
// The second CRC byte transfer of a good frame registers its result in a slot.
// Two result slots (output register plus skid) let bytes keep flowing while
//   a result waits; in_stall rises only when both slots are full.
// Reset: rst_n clears the parser to the sync hunt, restores the register
//   defaults and empties both result slots.
module crc16_framed_command_parser_core
#(
    parameter int MAX_PAYLOAD = cfcp_pkg::MAX_PAYLOAD
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [7:0]  wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  msg_type,
    output logic [7:0]  sequence_res,
    output logic [2:0]  command,
    output logic [31:0] value
);

    localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 2);

    logic [7:0]           sync_first_reg;
    logic [7:0]           sync_second_reg;
    cfcp_pkg::cmd_codes_t codes_reg;

    logic [2:0]           phase_reg,   phase_next;
    logic [7:0]           length_reg,  length_next;
    logic [7:0]           count_reg,   count_next;
    logic [15:0]          crc_reg,     crc_next;
    logic [7:0]           crc_lo_reg,  crc_lo_next;
    logic [7:0]           type_reg,    type_next;
    logic [7:0]           seq_reg,     seq_next;
    logic [31:0]          payload_reg, payload_next;

    logic                 head_valid_reg, head_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    cfcp_pkg::result_t    head_reg,    head_next;
    cfcp_pkg::result_t    skid_reg,    skid_next;

    cfcp_pkg::result_t    decoded;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 fire;
    logic [7:0]           count_inc;
    logic [1:0]           lane;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = head_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign count_inc = count_reg + 8'd1;
    assign lane      = 2'(count_reg - cfcp_pkg::LEN_MIN);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg        <= cfcp_pkg::RST_SYNC_FIRST;
            sync_second_reg       <= cfcp_pkg::RST_SYNC_SECOND;
            codes_reg.set_voltage <= cfcp_pkg::RST_CODE_SET_VOLTAGE;
            codes_reg.set_current <= cfcp_pkg::RST_CODE_SET_CURRENT;
            codes_reg.set_output  <= cfcp_pkg::RST_CODE_SET_OUTPUT;
            codes_reg.ping        <= cfcp_pkg::RST_CODE_PING;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cfcp_pkg::REG_SYNC_FIRST:       sync_first_reg        <= wr_data;
                cfcp_pkg::REG_SYNC_SECOND:      sync_second_reg       <= wr_data;
                cfcp_pkg::REG_CODE_SET_VOLTAGE: codes_reg.set_voltage <= wr_data;
                cfcp_pkg::REG_CODE_SET_CURRENT: codes_reg.set_current <= wr_data;
                cfcp_pkg::REG_CODE_SET_OUTPUT:  codes_reg.set_output  <= wr_data;
                cfcp_pkg::REG_CODE_PING:        codes_reg.ping        <= wr_data;
                default:                        ;
            endcase
        end
    end

    // Decode the frame held in the parser registers
    cfcp_decode u_decode
    (
        .codes         (codes_reg),
        .type_byte     (type_reg),
        .sequence_byte (seq_reg),
        .payload_word  (payload_reg),
        .frame_length  (length_reg),
        .result        (decoded)
    );

    // Parse one byte per transfer
    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        payload_next = payload_reg;
        fire         = 1'b0;

        if (in_xfer)
        begin
            case (phase_reg)
                cfcp_pkg::PH_SYNC1:
                begin
                    if (rx_byte == sync_first_reg)
                    begin
                        phase_next = cfcp_pkg::PH_SYNC2;
                    end
                end
                cfcp_pkg::PH_SYNC2:
                begin
                    // Second sync wins when both values match
                    if (rx_byte == sync_second_reg)
                    begin
                        phase_next = cfcp_pkg::PH_LENGTH;
                    end
                    else if (rx_byte != sync_first_reg)
                    begin
                        phase_next = cfcp_pkg::PH_SYNC1;
                    end
                end
                cfcp_pkg::PH_LENGTH:
                begin
                    if (rx_byte < cfcp_pkg::LEN_MIN || rx_byte > LEN_MAX)
                    begin
                        phase_next  = cfcp_pkg::PH_SYNC1;
                        length_next = 8'd0;
                        count_next  = 8'd0;
                        crc_next    = cfcp_pkg::CRC_INIT;
                        crc_lo_next = 8'd0;
                    end
                    else
                    begin
                        length_next  = rx_byte;
                        count_next   = 8'd0;
                        payload_next = 32'd0;
                        crc_next     = cfcp_pkg::crc16_byte(cfcp_pkg::CRC_INIT, rx_byte);
                        phase_next   = cfcp_pkg::PH_BODY;
                    end
                end
                cfcp_pkg::PH_BODY:
                begin
                    if (count_reg == 8'd0)
                    begin
                        type_next = rx_byte;
                    end
                    else if (count_reg == 8'd1)
                    begin
                        seq_next = rx_byte;
                    end
                    else if (count_reg < cfcp_pkg::WORD_END)
                    begin
                        payload_next[8*lane +: 8] = rx_byte;
                    end
                    count_next = count_inc;
                    crc_next   = cfcp_pkg::crc16_byte(crc_reg, rx_byte);
                    if (count_inc >= length_reg)
                    begin
                        phase_next = cfcp_pkg::PH_CRC_LO;
                    end
                end
                cfcp_pkg::PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = cfcp_pkg::PH_CRC_HI;
                end
                cfcp_pkg::PH_CRC_HI:
                begin
                    fire        = ({rx_byte, crc_lo_reg} == crc_reg);
                    phase_next  = cfcp_pkg::PH_SYNC1;
                    length_next = 8'd0;
                    count_next  = 8'd0;
                    crc_next    = cfcp_pkg::CRC_INIT;
                    crc_lo_next = 8'd0;
                end
                default:
                begin
                    phase_next  = cfcp_pkg::PH_SYNC1;
                    length_next = 8'd0;
                    count_next  = 8'd0;
                    crc_next    = cfcp_pkg::CRC_INIT;
                    crc_lo_next = 8'd0;
                end
            endcase
        end
    end

    // Hold results in the output register and the skid slot
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;

        if (!head_valid_reg)
        begin
            head_valid_next = fire;
            head_next       = decoded;
        end
        else if (out_xfer)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = fire;
                skid_next       = decoded;
            end
            else
            begin
                head_valid_next = fire;
                head_next       = decoded;
            end
        end
        else if (fire)
        begin
            skid_valid_next = 1'b1;
            skid_next       = decoded;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cfcp_pkg::PH_SYNC1;
            length_reg     <= 8'd0;
            count_reg      <= 8'd0;
            crc_reg        <= cfcp_pkg::CRC_INIT;
            crc_lo_reg     <= 8'd0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            length_reg     <= length_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            crc_lo_reg     <= crc_lo_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        seq_reg     <= seq_next;
        payload_reg <= payload_next;
        head_reg    <= head_next;
        skid_reg    <= skid_next;
    end

    // Drive the result channel
    assign out_valid    = head_valid_reg;
    assign status       = head_reg.status;
    assign msg_type     = head_reg.msg_type;
    assign sequence_res = head_reg.sequence_res;
    assign command      = head_reg.command;
    assign value        = head_reg.value;

endmodule

// ----- rtl/cfcp_decode.sv -----
// ----------------------------------------------------------------------------
// cfcp_decode: command decoder
// Maps the type byte, payload length and payload word of a checked frame
// to the status, command and value of the result.
// ----------------------------------------------------------------------------
module cfcp_decode
(
    input  cfcp_pkg::cmd_codes_t codes,
    input  logic [7:0]           type_byte,
    input  logic [7:0]           sequence_byte,
    input  logic [31:0]          payload_word,
    input  logic [7:0]           frame_length,
    output cfcp_pkg::result_t    result
);

    logic [7:0] plen;

    assign plen = frame_length - cfcp_pkg::LEN_MIN;

    // Match the type against the codes in priority order
    always_comb
    begin
        result.status       = cfcp_pkg::ST_ACCEPTED;
        result.msg_type     = type_byte;
        result.sequence_res = sequence_byte;
        result.command      = cfcp_pkg::CMD_NONE;
        result.value        = 32'd0;

        if (type_byte == codes.set_voltage || type_byte == codes.set_current)
        begin
            if (plen == cfcp_pkg::PLEN_TARGET)
            begin
                result.command = (type_byte == codes.set_voltage) ?
                                 cfcp_pkg::CMD_SET_VOLTAGE : cfcp_pkg::CMD_SET_CURRENT;
                result.value   = payload_word;
            end
            else
            begin
                result.status = cfcp_pkg::ST_BAD_PAYLOAD;
            end
        end
        else if (type_byte == codes.set_output)
        begin
            if (plen == cfcp_pkg::PLEN_OUTPUT && payload_word[7:1] == 7'd0)
            begin
                result.command = cfcp_pkg::CMD_SET_OUTPUT;
                result.value   = {24'd0, payload_word[7:0]};
            end
            else
            begin
                result.status = cfcp_pkg::ST_BAD_PAYLOAD;
            end
        end
        else if (type_byte == codes.ping)
        begin
            if (plen == cfcp_pkg::PLEN_PING)
            begin
                result.command = cfcp_pkg::CMD_PING;
            end
            else
            begin
                result.status = cfcp_pkg::ST_BAD_PAYLOAD;
            end
        end
        else
        begin
            result.status = cfcp_pkg::ST_UNKNOWN_TYPE;
        end
    end

endmodule

// ----- rtl/cfcp_checker.sv -----
// ----------------------------------------------------------------------------
// cfcp_checker: port-level checks for the framed command parser
// Watches the byte and result channels and reports violations.
// ----------------------------------------------------------------------------
module cfcp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [7:0]  msg_type,
    input logic [7:0]  sequence_res,
    input logic [2:0]  command,
    input logic [31:0] value
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(msg_type) &&
            $stable(sequence_res) && $stable(command) && $stable(value))
        else $error("stalled result changed");

    // Stall the byte channel only while a result is pending
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("byte channel stalled with no pending result");

    // A new result follows a byte transfer
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result appeared without a byte transfer");

endmodule

bind crc16_framed_command_parser_core cfcp_checker u_cfcp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .msg_type     (msg_type),
    .sequence_res (sequence_res),
    .command      (command),
    .value        (value)
);

// ----- verif/tb_crc16_framed_command_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_framed_command_parser_core: self-checking bench for the frame parser
// Sends framed byte streams (good frames, bad CRC, bad length, noise and cut
// off frames) under several sync/type-code settings, with random gaps and
// output stalls. A built-in parser model predicts each decoded command; every
// delivered command is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_crc16_framed_command_parser_core;

    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 145;
    localparam int TIMEOUT_CYCLES = 400_000;

    typedef logic [7:0] byte_q_t[$];

    // One directed frame; res is used only when typed is set
    typedef struct {
        logic [7:0]        len_b;
        logic [7:0]        typ;
        logic [7:0]        seq;
        logic [31:0]       word;
        bit                bad_crc;
        int                extra;
        bit                typed;
        cfcp_pkg::result_t res;
    } frame_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [7:0]  wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  sequence_res;
    logic [2:0]  command;
    logic [31:0] value;

    // Directed row index carried with each byte, -1 when untyped
    int          in_tag;

    bit          gaps_on;
    bit          stall_on;
    bit          hold_req;
    int          fail_count;

    // Parser model state
    logic [7:0]  cfg_regs [0:5];
    logic [2:0]  rx_phase;
    int          frame_len;
    int          body_cnt;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [7:0]  type_hold;
    logic [7:0]  seq_hold;
    logic [31:0] payload_hold;

    cfcp_pkg::result_t expected_cmds[$];
    frame_row_t        dir_rows[$];
    byte_q_t           none_q;

    crc16_framed_command_parser_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .msg_type     (msg_type),
        .sequence_res (sequence_res),
        .command      (command),
        .value        (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bit-serial CRC-16 update, feedback taken from the top bit
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ cfcp_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        rx_phase  = cfcp_pkg::PH_SYNC1;
        frame_len = 0;
        body_cnt  = 0;
        crc_acc   = cfcp_pkg::CRC_INIT;
        crc_rx    = '0;
    endfunction

    function automatic void reset_model();
        cfg_regs[cfcp_pkg::REG_SYNC_FIRST]       = cfcp_pkg::RST_SYNC_FIRST;
        cfg_regs[cfcp_pkg::REG_SYNC_SECOND]      = cfcp_pkg::RST_SYNC_SECOND;
        cfg_regs[cfcp_pkg::REG_CODE_SET_VOLTAGE] = cfcp_pkg::RST_CODE_SET_VOLTAGE;
        cfg_regs[cfcp_pkg::REG_CODE_SET_CURRENT] = cfcp_pkg::RST_CODE_SET_CURRENT;
        cfg_regs[cfcp_pkg::REG_CODE_SET_OUTPUT]  = cfcp_pkg::RST_CODE_SET_OUTPUT;
        cfg_regs[cfcp_pkg::REG_CODE_PING]        = cfcp_pkg::RST_CODE_PING;
        restart_hunt();
        type_hold    = '0;
        seq_hold     = '0;
        payload_hold = '0;
    endfunction

    // Decode a frame whose CRC matched; earlier codes win on shared values
    function automatic cfcp_pkg::result_t decode_frame();
        cfcp_pkg::result_t r;
        int                plen;
        logic [7:0]        t;
        plen           = frame_len - int'(cfcp_pkg::LEN_MIN);
        t              = type_hold;
        r.status       = cfcp_pkg::ST_ACCEPTED;
        r.msg_type     = t;
        r.sequence_res = seq_hold;
        r.command      = cfcp_pkg::CMD_NONE;
        r.value        = '0;
        if (t == cfg_regs[cfcp_pkg::REG_CODE_SET_VOLTAGE]
            || t == cfg_regs[cfcp_pkg::REG_CODE_SET_CURRENT])
        begin
            if (plen == int'(cfcp_pkg::PLEN_TARGET))
            begin
                r.command = (t == cfg_regs[cfcp_pkg::REG_CODE_SET_VOLTAGE])
                            ? cfcp_pkg::CMD_SET_VOLTAGE : cfcp_pkg::CMD_SET_CURRENT;
                r.value   = payload_hold;
            end
            else
                r.status = cfcp_pkg::ST_BAD_PAYLOAD;
        end
        else if (t == cfg_regs[cfcp_pkg::REG_CODE_SET_OUTPUT])
        begin
            if (plen == int'(cfcp_pkg::PLEN_OUTPUT) && payload_hold[7:0] <= 8'd1)
            begin
                r.command = cfcp_pkg::CMD_SET_OUTPUT;
                r.value   = {24'h0, payload_hold[7:0]};
            end
            else
                r.status = cfcp_pkg::ST_BAD_PAYLOAD;
        end
        else if (t == cfg_regs[cfcp_pkg::REG_CODE_PING])
        begin
            if (plen == int'(cfcp_pkg::PLEN_PING))
                r.command = cfcp_pkg::CMD_PING;
            else
                r.status = cfcp_pkg::ST_BAD_PAYLOAD;
        end
        else
            r.status = cfcp_pkg::ST_UNKNOWN_TYPE;
        return r;
    endfunction

    // Advance the parser model by one byte; returns 1 when a command comes out
    function automatic bit parse_rx_byte(input logic [7:0] b, output cfcp_pkg::result_t r);
        bit produced;
        produced = 1'b0;
        r        = '0;
        case (rx_phase)
            cfcp_pkg::PH_SYNC1:
                if (b == cfg_regs[cfcp_pkg::REG_SYNC_FIRST])
                    rx_phase = cfcp_pkg::PH_SYNC2;
            cfcp_pkg::PH_SYNC2:
                // second sync is tested first, so equal sync values still frame
                if (b == cfg_regs[cfcp_pkg::REG_SYNC_SECOND])
                    rx_phase = cfcp_pkg::PH_LENGTH;
                else if (b != cfg_regs[cfcp_pkg::REG_SYNC_FIRST])
                    rx_phase = cfcp_pkg::PH_SYNC1;
            cfcp_pkg::PH_LENGTH:
                if (b < cfcp_pkg::LEN_MIN || b > cfcp_pkg::LEN_MAX)
                    restart_hunt();
                else
                begin
                    frame_len    = int'(b);
                    body_cnt     = 0;
                    payload_hold = '0;
                    crc_acc      = crc16_step(cfcp_pkg::CRC_INIT, b);
                    rx_phase     = cfcp_pkg::PH_BODY;
                end
            cfcp_pkg::PH_BODY:
            begin
                if (body_cnt == 0)
                    type_hold = b;
                else if (body_cnt == 1)
                    seq_hold = b;
                else if (body_cnt < int'(cfcp_pkg::WORD_END))
                    payload_hold[8 * (body_cnt - 2) +: 8] = b;
                body_cnt++;
                crc_acc = crc16_step(crc_acc, b);
                if (body_cnt >= frame_len)
                    rx_phase = cfcp_pkg::PH_CRC_LO;
            end
            cfcp_pkg::PH_CRC_LO:
            begin
                crc_rx   = {8'h00, b};
                rx_phase = cfcp_pkg::PH_CRC_HI;
            end
            cfcp_pkg::PH_CRC_HI:
            begin
                crc_rx[15:8] = b;
                if (crc_rx == crc_acc)
                begin
                    r        = decode_frame();
                    produced = 1'b1;
                end
                restart_hunt();
            end
            default:
                restart_hunt();
        endcase
        return produced;
    endfunction

    function automatic byte_q_t make_payload(input int plen, input logic [31:0] w);
        byte_q_t q;
        for (int i = 0; i < plen; i++)
            q.push_back(i < 4 ? w[8 * i +: 8] : 8'($urandom));
        return q;
    endfunction

    function automatic void add_row(input logic [7:0] len_b, input logic [7:0] typ,
                                    input logic [7:0] seq, input logic [31:0] word,
                                    input bit bad_crc, input int extra, input bit typed,
                                    input logic [1:0] st, input logic [2:0] cmd,
                                    input logic [31:0] val);
        frame_row_t row;
        row.len_b            = len_b;
        row.typ              = typ;
        row.seq              = seq;
        row.word             = word;
        row.bad_crc          = bad_crc;
        row.extra            = extra;
        row.typed            = typed;
        row.res.status       = st;
        row.res.msg_type     = typ;
        row.res.sequence_res = seq;
        row.res.command      = cmd;
        row.res.value        = val;
        dir_rows.push_back(row);
    endfunction

    // Offer one byte, with an optional gap first; return once it transfers
    task automatic send_byte(input logic [7:0] b, input int tag);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        in_tag   <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Send sync, length and, for a legal length, the body and CRC
    task automatic send_frame(input logic [7:0] len_b, input logic [7:0] typ,
                              input logic [7:0] seq, input byte_q_t pay,
                              input bit bad_crc, input int extra, input int tag);
        logic [15:0] crc;
        send_byte(cfg_regs[cfcp_pkg::REG_SYNC_FIRST], -1);
        repeat (extra) send_byte(cfg_regs[cfcp_pkg::REG_SYNC_FIRST], -1);
        send_byte(cfg_regs[cfcp_pkg::REG_SYNC_SECOND], -1);
        send_byte(len_b, -1);
        if (len_b >= cfcp_pkg::LEN_MIN && len_b <= cfcp_pkg::LEN_MAX)
        begin
            crc = crc16_step(cfcp_pkg::CRC_INIT, len_b);
            crc = crc16_step(crc, typ);
            send_byte(typ, -1);
            crc = crc16_step(crc, seq);
            send_byte(seq, -1);
            foreach (pay[i])
            begin
                crc = crc16_step(crc, pay[i]);
                send_byte(pay[i], -1);
            end
            if (bad_crc)
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            send_byte(crc[7:0], -1);
            send_byte(crc[15:8], tag);
        end
    endtask

    // Pick one random stimulus unit; n is what it adds to the phase byte count
    task automatic send_random_frame(output int n);
        int          pick;
        int          k;
        int          plen;
        int          extra;
        int          cnt;
        bit          bad;
        logic [7:0]  typ;
        logic [7:0]  lb;
        logic [31:0] w;
        pick  = $urandom_range(0, 99);
        k     = $urandom_range(0, 3);
        typ   = cfg_regs[int'(cfcp_pkg::REG_CODE_SET_VOLTAGE) + k];
        w     = $urandom;
        bad   = 1'b0;
        extra = 0;
        n     = 0;
        case (k)
            0, 1:    plen = int'(cfcp_pkg::PLEN_TARGET);
            2:
            begin
                plen = int'(cfcp_pkg::PLEN_OUTPUT);
                w    = $urandom_range(0, 1);
            end
            default: plen = int'(cfcp_pkg::PLEN_PING);
        endcase
        if (cfg_regs[cfcp_pkg::REG_SYNC_FIRST] != cfg_regs[cfcp_pkg::REG_SYNC_SECOND]
            && $urandom_range(0, 9) == 0)
            extra = $urandom_range(1, 3);

        if (pick < 58 || (pick >= 76 && pick < 84))
        begin
            // well-formed command, CRC corrupted in part of the cases
            bad = (pick >= 76);
            send_frame(8'(plen + 2), typ, 8'($urandom), make_payload(plen, w), bad,
                       extra, -1);
            n = plen + 6 + extra;
        end
        else if (pick < 76)
        begin
            if (pick < 68)
            begin
                // known type with a random payload length or, for output, a bad value
                plen = $urandom_range(0, 8);
                if (k == 2 && $urandom_range(0, 1) == 0)
                begin
                    plen = int'(cfcp_pkg::PLEN_OUTPUT);
                    w    = $urandom_range(2, 255);
                end
            end
            else
            begin
                typ  = 8'($urandom);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cfcp_pkg::MAX_PAYLOAD)
                                                   : $urandom_range(0, 6);
            end
            send_frame(8'(plen + 2), typ, 8'($urandom), make_payload(plen, w), 1'b0,
                       extra, -1);
            n = plen + 6 + extra;
        end
        else if (pick < 90)
        begin
            lb = ($urandom_range(0, 1) == 0)
                 ? 8'($urandom_range(0, int'(cfcp_pkg::LEN_MIN) - 1))
                 : 8'($urandom_range(int'(cfcp_pkg::LEN_MAX) + 1, 255));
            send_frame(lb, 8'h00, 8'h00, none_q, 1'b0, 0, -1);
            n = 3;
        end
        else if (pick < 95)
        begin
            // line noise
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), -1);
        end
        else
        begin
            // frame cut short; the next bytes land in its body
            send_byte(cfg_regs[cfcp_pkg::REG_SYNC_FIRST], -1);
            send_byte(cfg_regs[cfcp_pkg::REG_SYNC_SECOND], -1);
            lb = 8'($urandom_range(int'(cfcp_pkg::LEN_MIN), 8));
            send_byte(lb, -1);
            cnt = $urandom_range(0, int'(lb));
            repeat (cnt) send_byte(8'($urandom), -1);
            n = 3 + cnt;
        end
    endtask

    // Write every register (vals[i] to register i), then the two unused indexes
    task automatic configure(input logic [0:5][7:0] vals);
        for (int i = 0; i < 8; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= 3'(i);
            wr_data  <= (i <= int'(cfcp_pkg::REG_CODE_PING)) ? vals[i] : 8'($urandom);
            @(posedge clk);
        end
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every predicted command has been delivered
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [0:5][7:0] vals, input bit with_hold, input bit quiet);
        int count;
        int n;
        bit hold_done;
        count     = 0;
        hold_done = 1'b0;
        gaps_on   = !quiet;
        stall_on  = !quiet;
        configure(vals);
        while (count < PHASE_BYTES)
        begin
            if (with_hold && !hold_done && count >= PHASE_BYTES / 3)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!quiet && $urandom_range(0, 15) == 0)
            begin
                gaps_on  = $urandom_range(0, 2) != 0;
                stall_on = $urandom_range(0, 2) != 0;
            end
            send_random_frame(n);
            count += n;
        end
        drain();
    endtask

    // Result side: random stall bursts and, on request, one long hold-off
    initial
    begin
        int hold_count;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check delivered commands, track register writes, predict on each byte transfer
    always @(posedge clk)
    begin
        cfcp_pkg::result_t fresh;
        cfcp_pkg::result_t want;
        bit                produced;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"unexpected command: status=%0d type=%02h seq=%02h",
                                  " cmd=%0d value=%08h"},
                                 status, msg_type, sequence_res, command, value);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (status !== want.status || msg_type !== want.msg_type
                        || sequence_res !== want.sequence_res || command !== want.command
                        || value !== want.value)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"command mismatch: exp status=%0d type=%02h seq=%02h",
                                      " cmd=%0d value=%08h, got status=%0d type=%02h",
                                      " seq=%02h cmd=%0d value=%08h"},
                                     want.status, want.msg_type, want.sequence_res,
                                     want.command, want.value, status, msg_type,
                                     sequence_res, command, value);
                    end
                end
            end
            if (wr_en && wr_index <= cfcp_pkg::REG_CODE_PING)
                cfg_regs[wr_index] = wr_data;
            if (in_valid && !in_stall)
            begin
                produced = parse_rx_byte(rx_byte, fresh);
                if (in_tag >= 0)
                    expected_cmds.push_back(dir_rows[in_tag].res);
                else if (produced)
                    expected_cmds.push_back(fresh);
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [7:0] v;
        rst_n    <= 1'b0;
        wr_en    <= 1'b0;
        wr_index <= '0;
        wr_data  <= '0;
        in_valid <= 1'b0;
        rx_byte  <= '0;
        in_tag   <= -1;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        hold_req   = 1'b0;
        fail_count = 0;
        reset_model();

        // Directed frames under the reset register values
        //      len   type   seq   payload word   crc  rep  typed
        add_row(8'd2, cfcp_pkg::RST_CODE_PING, 8'h00, 32'h0, 0, 0, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_PING, 32'h0);
        add_row(8'd6, cfcp_pkg::RST_CODE_SET_VOLTAGE, 8'hFF, 32'hFFFF_FFFF, 0, 0, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_SET_VOLTAGE, 32'hFFFF_FFFF);
        add_row(8'd6, cfcp_pkg::RST_CODE_SET_CURRENT, 8'h80, 32'h0, 0, 0, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_SET_CURRENT, 32'h0);
        add_row(8'd6, cfcp_pkg::RST_CODE_SET_CURRENT, 8'h5A, 32'h1234_5678, 0, 0, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_SET_CURRENT, 32'h1234_5678);
        add_row(8'd3, cfcp_pkg::RST_CODE_SET_OUTPUT, 8'h01, 32'h1, 0, 0, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_SET_OUTPUT, 32'h1);
        add_row(8'd3, cfcp_pkg::RST_CODE_SET_OUTPUT, 8'h02, 32'h0, 0, 0, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_SET_OUTPUT, 32'h0);
        add_row(8'd3, cfcp_pkg::RST_CODE_SET_OUTPUT, 8'h03, 32'h2, 0, 0, 1,
                cfcp_pkg::ST_BAD_PAYLOAD, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd5, cfcp_pkg::RST_CODE_SET_VOLTAGE, 8'h04, 32'h00AB_CDEF, 0, 0, 1,
                cfcp_pkg::ST_BAD_PAYLOAD, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd3, cfcp_pkg::RST_CODE_PING, 8'h05, 32'h77, 0, 0, 1,
                cfcp_pkg::ST_BAD_PAYLOAD, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd2, 8'h00, 8'h06, 32'h0, 0, 0, 1,
                cfcp_pkg::ST_UNKNOWN_TYPE, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(cfcp_pkg::LEN_MAX, 8'hFF, 8'h07, 32'hDEAD_BEEF, 0, 0, 1,
                cfcp_pkg::ST_UNKNOWN_TYPE, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(cfcp_pkg::LEN_MAX, cfcp_pkg::RST_CODE_SET_VOLTAGE, 8'h08, 32'hCAFE_F00D,
                0, 0, 1, cfcp_pkg::ST_BAD_PAYLOAD, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd2, cfcp_pkg::RST_CODE_PING, 8'h09, 32'h0, 1, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd1, cfcp_pkg::RST_CODE_PING, 8'h00, 32'h0, 0, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(cfcp_pkg::LEN_MAX + 8'd1, cfcp_pkg::RST_CODE_PING, 8'h00, 32'h0, 0, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd0, cfcp_pkg::RST_CODE_PING, 8'h00, 32'h0, 0, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'hFF, cfcp_pkg::RST_CODE_PING, 8'h00, 32'h0, 0, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd2, cfcp_pkg::RST_CODE_PING, 8'h0A, 32'h0, 0, 2, 1,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_PING, 32'h0);
        add_row(8'd6, cfcp_pkg::RST_CODE_SET_VOLTAGE, 8'h0B, 32'hA5A5_5A5A, 0, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);
        add_row(8'd9, cfcp_pkg::RST_CODE_SET_CURRENT, 8'h0C, 32'h0102_0304, 0, 0, 0,
                cfcp_pkg::ST_ACCEPTED, cfcp_pkg::CMD_NONE, 32'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unused indexes right after reset must leave the defaults alone
        for (int i = int'(cfcp_pkg::REG_CODE_PING) + 1; i < 8; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= 3'(i);
            wr_data  <= 8'($urandom);
            @(posedge clk);
        end
        wr_en <= 1'b0;
        @(posedge clk);

        // Walk the directed rows
        foreach (dir_rows[i])
            send_frame(dir_rows[i].len_b, dir_rows[i].typ, dir_rows[i].seq,
                       make_payload((dir_rows[i].len_b >= cfcp_pkg::LEN_MIN
                                     && dir_rows[i].len_b <= cfcp_pkg::LEN_MAX)
                                    ? int'(dir_rows[i].len_b) - int'(cfcp_pkg::LEN_MIN)
                                    : 0,
                                    dir_rows[i].word),
                       dir_rows[i].bad_crc, dir_rows[i].extra,
                       dir_rows[i].typed ? i : -1);
        drain();

        // Extreme values, with a long hold-off on the result side
        run_phase({8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F}, 1'b1, 1'b0);
        // Equal sync values and shared type codes
        run_phase({8'h7E, 8'h7E, 8'h10, 8'h10, 8'h20, 8'h20}, 1'b0, 1'b0);
        // Fully random settings, hold-off again
        run_phase({8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom)}, 1'b1, 1'b0);
        v = 8'($urandom);
        run_phase({8'hFF, 8'h00, v, 8'($urandom), v ^ 8'h01, 8'($urandom)}, 1'b0, 1'b0);
        // Back to the reset values, no idling on either side
        run_phase({cfcp_pkg::RST_SYNC_FIRST, cfcp_pkg::RST_SYNC_SECOND,
                   cfcp_pkg::RST_CODE_SET_VOLTAGE, cfcp_pkg::RST_CODE_SET_CURRENT,
                   cfcp_pkg::RST_CODE_SET_OUTPUT, cfcp_pkg::RST_CODE_PING}, 1'b0, 1'b1);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("FAIL");
        $finish;
    end

endmodule
